@@ rtl/core/pvp_pkg.sv @@
// pvp_pkg: widths, constants and pipeline types shared by the
// perpendicular vector pair block. No dependencies.
package pvp_pkg;

  localparam int unsigned VAL_W       = 16;
  localparam int unsigned LEN_W       = 15;
  localparam int unsigned SHIFT_LIMIT = 20;
  localparam int unsigned GUARD       = 11;
  localparam int unsigned SUMSQ_W     = 42;
  localparam int unsigned RAD_W       = 64;
  localparam int unsigned ROOT_W      = 32;
  localparam int unsigned REM_W       = 36;
  localparam int unsigned PROD_W      = LEN_W + SHIFT_LIMIT;
  localparam int unsigned NUM_W       = PROD_W + GUARD + 1;
  localparam int unsigned QUO_W       = 16;
  localparam int unsigned IN_CW       = VAL_W + 1;
  localparam int unsigned CROSS_W     = 2 * VAL_W + 1;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(256);

  typedef logic signed [VAL_W-1:0] val_t;

  // one square root cell: radicand still to consume, partial remainder and root
  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  // one divider cell, three lanes sharing a divisor
  typedef struct packed {
    logic [2:0][NUM_W-1:0] rem;
    logic [2:0][QUO_W-1:0] quo;
    logic [ROOT_W-1:0]     den;
  } div_t;

endpackage

@@ rtl/core/pvp_in_if.sv @@
// pvp_in_if: request channel carrying one input vector.
// Depends on pvp_pkg.
interface pvp_in_if;
  logic          valid;
  logic          ready;
  pvp_pkg::val_t in_x;
  pvp_pkg::val_t in_y;
  pvp_pkg::val_t in_z;

  modport source (output valid, in_x, in_y, in_z, input ready);
  modport sink (input valid, in_x, in_y, in_z, output ready);
endinterface

@@ rtl/core/pvp_out_if.sv @@
// pvp_out_if: result channel carrying the two perpendicular vectors.
// Depends on pvp_pkg.
interface pvp_out_if;
  logic          valid;
  logic          ready;
  pvp_pkg::val_t first_x;
  pvp_pkg::val_t first_y;
  pvp_pkg::val_t first_z;
  pvp_pkg::val_t second_x;
  pvp_pkg::val_t second_y;
  pvp_pkg::val_t second_z;
  logic          zero_input;

  modport source (output valid, first_x, first_y, first_z, second_x, second_y, second_z,
                  zero_input, input ready);
  modport sink (input valid, first_x, first_y, first_z, second_x, second_y, second_z,
                zero_input, output ready);
endinterface

@@ rtl/core/perpendicular_vector_pair.sv @@
// perpendicular_vector_pair: two perpendicular vectors of a set length from a
// 3-D input vector. Depends on pvp_pkg, pvp_in_if, pvp_out_if, pvp_scale.
// Two scaling chains, each built around its 32-cell square root and 16-cell
// divider, with one registered cross product stage between them. Throughput:
// one request per cycle; a held result freezes the whole chain. Reset clears
// all stage valids and sets the length to 256.
module perpendicular_vector_pair (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pvp_pkg::LEN_W-1:0]     cfg_data_i,
  pvp_in_if.sink                        req_i,
  pvp_out_if.source                     res_o
);
  import pvp_pkg::*;

  localparam int unsigned SB1_W = 3 * VAL_W;
  localparam int unsigned SB2_W = 3 * VAL_W + 1;

  logic             adv;
  logic [LEN_W-1:0] len_q;

  // length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
    end else if (cfg_we_i) begin
      len_q <= cfg_data_i;
    end
  end

  // whole chain moves unless a finished result is held
  assign adv         = !res_o.valid || res_o.ready;
  assign req_i.ready = adv;

  // first vector direction (y, -x, 0)
  logic [2:0][IN_CW-1:0] c1;
  logic [IN_CW-1:0]      xe;

  always_comb begin
    xe    = {req_i.in_x[VAL_W-1], req_i.in_x};
    c1[0] = {req_i.in_y[VAL_W-1], req_i.in_y};
    c1[1] = ~xe + IN_CW'(1);
    c1[2] = '0;
  end

  logic             v1;
  val_t [2:0]       q1;
  logic [SB1_W-1:0] sb1;

  pvp_scale #(.CW(IN_CW), .SBW(SB1_W)) u_scale_first (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (req_i.valid),
    .c_i     (c1),
    .len_i   (len_q),
    .sb_i    ({req_i.in_z, req_i.in_y, req_i.in_x}),
    .valid_o (v1),
    .q_o     (q1),
    .sb_o    (sb1)
  );

  // cross product of the input with the first vector
  val_t                    x, y, z;
  val_t [2:0]              f_d;
  logic signed [2*VAL_W-1:0] p_zf1, p_zf0, p_xf1, p_yf0;
  logic [2:0][CROSS_W-1:0] c2_d;
  logic                    zero_d;

  always_comb begin
    x      = sb1[VAL_W-1:0];
    y      = sb1[2*VAL_W-1:VAL_W];
    z      = sb1[3*VAL_W-1:2*VAL_W];
    zero_d = (x == '0) && (y == '0) && (z == '0);
    if ((x == '0) && (y == '0)) begin
      f_d[0] = val_t'({1'b0, len_q});
      f_d[1] = '0;
      f_d[2] = '0;
    end else begin
      f_d = q1;
    end
    p_zf1 = z * f_d[1];
    p_zf0 = z * f_d[0];
    p_xf1 = x * f_d[1];
    p_yf0 = y * f_d[0];
    c2_d[0] = ~{p_zf1[2*VAL_W-1], p_zf1} + CROSS_W'(1);
    c2_d[1] = {p_zf0[2*VAL_W-1], p_zf0};
    c2_d[2] = {p_xf1[2*VAL_W-1], p_xf1} - {p_yf0[2*VAL_W-1], p_yf0};
  end

  logic                    vc_q;
  logic [2:0][CROSS_W-1:0] c2_q;
  val_t [2:0]              f_q;
  logic                    zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= v1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c2_q   <= c2_d;
      f_q    <= f_d;
      zero_q <= zero_d;
    end
  end

  logic             v2;
  val_t [2:0]       q2;
  logic [SB2_W-1:0] sb2;

  pvp_scale #(.CW(CROSS_W), .SBW(SB2_W)) u_scale_second (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (vc_q),
    .c_i     (c2_q),
    .len_i   (len_q),
    .sb_i    ({zero_q, f_q}),
    .valid_o (v2),
    .q_o     (q2),
    .sb_o    (sb2)
  );

  // result fields; an all-zero input forces a zero second vector
  logic zero_o;
  assign zero_o           = sb2[SB2_W-1];
  assign res_o.valid      = v2;
  assign res_o.first_x    = sb2[VAL_W-1:0];
  assign res_o.first_y    = sb2[2*VAL_W-1:VAL_W];
  assign res_o.first_z    = sb2[3*VAL_W-1:2*VAL_W];
  assign res_o.second_x   = zero_o ? val_t'(0) : q2[0];
  assign res_o.second_y   = zero_o ? val_t'(0) : q2[1];
  assign res_o.second_z   = zero_o ? val_t'(0) : q2[2];
  assign res_o.zero_input = zero_o;
endmodule

@@ rtl/core/pvp_sqrt_cell.sv @@
// pvp_sqrt_cell: one digit of a pipelined integer square root, two radicand
// bits per cell, with a pass-through payload. Depends on pvp_pkg.
module pvp_sqrt_cell #(
  parameter int unsigned PW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  pvp_pkg::sqrt_t  s_i,
  input  logic [PW-1:0]   pl_i,
  output logic            valid_o,
  output pvp_pkg::sqrt_t  s_o,
  output logic [PW-1:0]   pl_o
);
  import pvp_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  sqrt_t            s_d;
  logic             valid_q;
  sqrt_t            s_q;
  logic [PW-1:0]    pl_q;

  // trial subtract of 4*root+1 against the shifted remainder
  always_comb begin
    rem_sh   = {s_i.rem[REM_W-3:0], s_i.rad[RAD_W-1 -: 2]};
    trial    = {{(REM_W-ROOT_W-2){1'b0}}, s_i.root, 2'b01};
    ge       = (rem_sh >= trial);
    s_d.rad  = {s_i.rad[RAD_W-3:0], 2'b00};
    s_d.rem  = ge ? (rem_sh - trial) : rem_sh;
    s_d.root = {s_i.root[ROOT_W-2:0], ge};
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s_q  <= s_d;
      pl_q <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign pl_o    = pl_q;
endmodule

@@ rtl/core/pvp_div_cell.sv @@
// pvp_div_cell: one quotient bit of a pipelined restoring divider, three
// lanes over a shared divisor, with a pass-through payload. Depends on pvp_pkg.
module pvp_div_cell #(
  parameter int unsigned PW  = 8,
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           adv_i,
  input  logic           valid_i,
  input  pvp_pkg::div_t  d_i,
  input  logic [PW-1:0]  pl_i,
  output logic           valid_o,
  output pvp_pkg::div_t  d_o,
  output logic [PW-1:0]  pl_o
);
  import pvp_pkg::*;

  logic [NUM_W-1:0] den_sh;
  div_t             d_d;
  logic             valid_q;
  div_t             d_q;
  logic [PW-1:0]    pl_q;

  // compare and subtract the aligned divisor in each lane
  always_comb begin
    den_sh = {{(NUM_W-ROOT_W){1'b0}}, d_i.den} << BIT;
    d_d    = d_i;
    for (int i = 0; i < 3; i++) begin
      if (d_i.rem[i] >= den_sh) begin
        d_d.rem[i]      = d_i.rem[i] - den_sh;
        d_d.quo[i][BIT] = 1'b1;
      end
    end
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      d_q  <= d_d;
      pl_q <= pl_i;
    end
  end

  assign valid_o = valid_q;
  assign d_o     = d_q;
  assign pl_o    = pl_q;
endmodule

@@ rtl/core/pvp_scale.sv @@
// pvp_scale: scales a 3-D integer vector to a given length with rounding and
// saturation; magnitude, shift, square stages, a square root cell chain and a
// divider cell chain. Depends on pvp_pkg, pvp_sqrt_cell, pvp_div_cell.
module pvp_scale #(
  parameter int unsigned CW  = 17,
  parameter int unsigned SBW = 48
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          adv_i,
  input  logic                          valid_i,
  input  logic [2:0][CW-1:0]            c_i,
  input  logic [pvp_pkg::LEN_W-1:0]     len_i,
  input  logic [SBW-1:0]                sb_i,
  output logic                          valid_o,
  output pvp_pkg::val_t [2:0]           q_o,
  output logic [SBW-1:0]                sb_o
);
  import pvp_pkg::*;

  localparam int unsigned MW   = (CW > SHIFT_LIMIT) ? CW : SHIFT_LIMIT;
  localparam int unsigned KMAX = MW - SHIFT_LIMIT;
  localparam int unsigned KW   = $clog2(KMAX + 2);
  localparam int unsigned PLS  = SBW + 3 + 3 * PROD_W;
  localparam int unsigned PLD  = SBW + 3;

  // magnitude stage
  logic                        v1_q;
  logic [2:0][MW-1:0]          mag1_q;
  logic [2:0]                  neg1_q;
  logic [MW-1:0]               max1_q;
  logic [SBW-1:0]              sb1_q;
  logic [2:0][MW-1:0]          mag1_d;
  logic [2:0]                  neg1_d;
  logic [MW-1:0]               max1_d;
  logic [CW-1:0]               abs_c;

  always_comb begin
    max1_d = '0;
    for (int i = 0; i < 3; i++) begin
      neg1_d[i] = c_i[i][CW-1];
      abs_c     = neg1_d[i] ? (~c_i[i] + CW'(1)) : c_i[i];
      mag1_d[i] = MW'(abs_c);
      if (mag1_d[i] > max1_d) begin
        max1_d = mag1_d[i];
      end
    end
  end

  // shift stage: smallest shift that brings the largest magnitude under the limit
  logic                             v2_q;
  logic [2:0][SHIFT_LIMIT-1:0]      mag2_q;
  logic [2:0]                       neg2_q;
  logic [SBW-1:0]                   sb2_q;
  logic [KW-1:0]                    ksel;
  logic [2:0][SHIFT_LIMIT-1:0]      mag2_d;
  logic [MW-1:0]                    sh_tmp;

  always_comb begin
    ksel = KW'(KMAX);
    for (int k = KMAX; k >= 0; k--) begin
      if (((max1_q >> k) >> SHIFT_LIMIT) == '0) begin
        ksel = KW'(k);
      end
    end
    for (int i = 0; i < 3; i++) begin
      sh_tmp    = mag1_q[i] >> ksel;
      mag2_d[i] = sh_tmp[SHIFT_LIMIT-1:0];
    end
  end

  // square and product stage
  logic                        v3_q;
  logic [SUMSQ_W-1:0]          n2_q;
  logic [2:0][PROD_W-1:0]      prod_q;
  logic [2:0]                  neg3_q;
  logic [SBW-1:0]              sb3_q;
  logic [SUMSQ_W-1:0]          n2_d;
  logic [2:0][PROD_W-1:0]      prod_d;
  logic [2*SHIFT_LIMIT-1:0]    sq_tmp;

  always_comb begin
    n2_d = '0;
    for (int i = 0; i < 3; i++) begin
      sq_tmp    = mag2_q[i] * mag2_q[i];
      n2_d      = n2_d + SUMSQ_W'(sq_tmp);
      prod_d[i] = PROD_W'(len_i) * PROD_W'(mag2_q[i]);
    end
  end

  // front stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // front stage payload
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      mag1_q <= mag1_d;
      neg1_q <= neg1_d;
      max1_q <= max1_d;
      sb1_q  <= sb_i;
      mag2_q <= mag2_d;
      neg2_q <= neg1_q;
      sb2_q  <= sb1_q;
      n2_q   <= n2_d;
      prod_q <= prod_d;
      neg3_q <= neg2_q;
      sb3_q  <= sb2_q;
    end
  end

  // square root chain, one root bit per cell
  logic [ROOT_W:0] sq_v;
  sqrt_t           sq_s  [ROOT_W+1];
  logic [PLS-1:0]  sq_pl [ROOT_W+1];

  assign sq_v[0]       = v3_q;
  assign sq_s[0].rad   = {n2_q, {(RAD_W-SUMSQ_W){1'b0}}};
  assign sq_s[0].rem   = '0;
  assign sq_s[0].root  = '0;
  assign sq_pl[0]      = {sb3_q, neg3_q, prod_q};

  for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
    pvp_sqrt_cell #(.PW(PLS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (sq_v[j]),
      .s_i     (sq_s[j]),
      .pl_i    (sq_pl[j]),
      .valid_o (sq_v[j+1]),
      .s_o     (sq_s[j+1]),
      .pl_o    (sq_pl[j+1])
    );
  end

  // numerator stage: len*mag*2^guard plus half the norm for rounding
  logic                   vn_q;
  div_t                   dn_q;
  logic [PLD-1:0]         pln_q;
  div_t                   dn_d;
  logic [ROOT_W-1:0]      root;
  logic [2:0][PROD_W-1:0] prod_s;

  always_comb begin
    root   = sq_s[ROOT_W].root;
    prod_s = sq_pl[ROOT_W][3*PROD_W-1:0];
    dn_d.den = root;
    for (int i = 0; i < 3; i++) begin
      dn_d.rem[i] = {1'b0, prod_s[i], {GUARD{1'b0}}}
                  + {{(NUM_W-ROOT_W+1){1'b0}}, root[ROOT_W-1:1]};
      dn_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else if (adv_i) begin
      vn_q <= sq_v[ROOT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dn_q  <= dn_d;
      pln_q <= sq_pl[ROOT_W][PLS-1 -: PLD];
    end
  end

  // divider chain, one quotient bit per cell from the top
  logic [QUO_W:0] dv_v;
  div_t           dv_d  [QUO_W+1];
  logic [PLD-1:0] dv_pl [QUO_W+1];

  assign dv_v[0]  = vn_q;
  assign dv_d[0]  = dn_q;
  assign dv_pl[0] = pln_q;

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    pvp_div_cell #(.PW(PLD), .BIT(QUO_W - 1 - j)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv_i),
      .valid_i (dv_v[j]),
      .d_i     (dv_d[j]),
      .pl_i    (dv_pl[j]),
      .valid_o (dv_v[j+1]),
      .d_o     (dv_d[j+1]),
      .pl_o    (dv_pl[j+1])
    );
  end

  // sign and saturation stage; a zero vector has a zero norm and gives zero
  logic                vo_q;
  val_t [2:0]          qo_q;
  logic [SBW-1:0]      sbo_q;
  val_t [2:0]          qo_d;
  logic [2:0]          neg_o;
  logic [QUO_W-1:0]    quo;

  always_comb begin
    neg_o = dv_pl[QUO_W][2:0];
    for (int i = 0; i < 3; i++) begin
      quo = dv_d[QUO_W].quo[i];
      if (dv_d[QUO_W].den == '0) begin
        qo_d[i] = '0;
      end else if (neg_o[i]) begin
        qo_d[i] = val_t'(~quo + QUO_W'(1));
      end else if (quo[QUO_W-1]) begin
        qo_d[i] = val_t'({1'b0, {(VAL_W-1){1'b1}}});
      end else begin
        qo_d[i] = val_t'(quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (adv_i) begin
      vo_q <= dv_v[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      qo_q  <= qo_d;
      sbo_q <= dv_pl[QUO_W][PLD-1 -: SBW];
    end
  end

  assign valid_o = vo_q;
  assign q_o     = qo_q;
  assign sb_o    = sbo_q;
endmodule

@@ bench/perpendicular_vector_pair_tb.sv @@
// perpendicular_vector_pair_tb: drives input vectors into the block and checks
// every result against a built-in predictor or a typed expected pair. Depends on
// pvp_pkg, pvp_in_if, pvp_out_if and perpendicular_vector_pair.
module perpendicular_vector_pair_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvp_pkg::*;

  typedef longint vec3_t [3];

  typedef struct {
    val_t x, y, z;
  } vec_req_t;

  typedef struct {
    val_t f_x, f_y, f_z, s_x, s_y, s_z;
    logic zero;
  } pair_t;

  typedef struct {
    val_t  x, y, z;
    bit    typed;
    pair_t pair;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [LEN_W-1:0] cfg_data_i = '0;

  pvp_in_if  req_if ();
  pvp_out_if res_if ();

  pair_t pending_pairs [$];
  longint unsigned cur_len = 256;
  int  fail_count = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;
  int  hold_left = 0;

  perpendicular_vector_pair dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_if.sink),
    .res_o      (res_if.source)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // direction of c rescaled to len, rounded half away and saturated
  function automatic vec3_t rescale(vec3_t c, longint unsigned len);
    vec3_t o;
    longint unsigned mag [3];
    bit neg [3];
    longint unsigned m, n2, h, q;
    int k;
    m = 0;
    n2 = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      mag[i] = neg[i] ? longint'(-c[i]) : c[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    while ((m >> k) >= (64'd1 << SHIFT_LIMIT)) k++;
    for (int i = 0; i < 3; i++) begin
      mag[i] >>= k;
      n2 += mag[i] * mag[i];
    end
    h = int_sqrt(n2 << (2 * GUARD));
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (h != 0) q = (((len * mag[i]) << GUARD) + h / 2) / h;
      if (neg[i]) begin
        if (q > 32768) q = 32768;
        o[i] = -longint'(q);
      end else begin
        if (q > 32767) q = 32767;
        o[i] = q;
      end
    end
    return o;
  endfunction

  function automatic pair_t predict_pair(vec_req_t r, longint unsigned len);
    pair_t p;
    longint x, y, z;
    vec3_t f, c, s;
    bit zero;
    x = r.x;
    y = r.y;
    z = r.z;
    zero = (x == 0 && y == 0 && z == 0);
    if (x == 0 && y == 0) begin
      f = '{longint'(len), 0, 0};
    end else begin
      c = '{y, -x, 0};
      f = rescale(c, len);
    end
    c = '{-z * f[1], z * f[0], x * f[1] - y * f[0]};
    if (zero) s = '{0, 0, 0};
    else s = rescale(c, len);
    p.f_x = val_t'(f[0]);
    p.f_y = val_t'(f[1]);
    p.f_z = val_t'(f[2]);
    p.s_x = val_t'(s[0]);
    p.s_y = val_t'(s[1]);
    p.s_z = val_t'(s[2]);
    p.zero = zero;
    return p;
  endfunction

  // result receiver: random ready, one long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      res_if.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= calm || ($urandom_range(99) >= 27);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    pair_t e;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_pairs.size() == 0) begin
        $error("unexpected result");
        fail_count++;
      end else begin
        e = pending_pairs.pop_front();
        if (res_if.first_x !== e.f_x) begin
          $error("first_x exp %0d got %0d", e.f_x, res_if.first_x); fail_count++;
        end
        if (res_if.first_y !== e.f_y) begin
          $error("first_y exp %0d got %0d", e.f_y, res_if.first_y); fail_count++;
        end
        if (res_if.first_z !== e.f_z) begin
          $error("first_z exp %0d got %0d", e.f_z, res_if.first_z); fail_count++;
        end
        if (res_if.second_x !== e.s_x) begin
          $error("second_x exp %0d got %0d", e.s_x, res_if.second_x); fail_count++;
        end
        if (res_if.second_y !== e.s_y) begin
          $error("second_y exp %0d got %0d", e.s_y, res_if.second_y); fail_count++;
        end
        if (res_if.second_z !== e.s_z) begin
          $error("second_z exp %0d got %0d", e.s_z, res_if.second_z); fail_count++;
        end
        if (res_if.zero_input !== e.zero) begin
          $error("zero_input exp %0b got %0b", e.zero, res_if.zero_input); fail_count++;
        end
      end
    end
  end

  // offer one request, idling at random, and record its expected pair on accept
  task automatic send_vec(vec_req_t r, bit typed, pair_t typed_pair);
    @(negedge clk_i);
    while (!calm && $urandom_range(99) < 27) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.in_x <= r.x;
    req_if.in_y <= r.y;
    req_if.in_z <= r.z;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    pending_pairs.push_back(typed ? typed_pair : predict_pair(r, cur_len));
  endtask

  task automatic send_plain(val_t x, val_t y, val_t z);
    vec_req_t r;
    pair_t none;
    r = '{x, y, z};
    none = '{default: '0};
    send_vec(r, 1'b0, none);
  endtask

  // write the length once the pipeline has drained
  task automatic set_length(longint unsigned len);
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= LEN_W'(len);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_len = len;
  endtask

  task automatic random_batch(int count);
    val_t x, y, z;
    for (int i = 0; i < count; i++) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
      case ($urandom_range(7))
        0: begin x = 0; y = 0; end
        1: begin x = $urandom_range(7) - 3; y = $urandom_range(7) - 3;
                 z = $urandom_range(7) - 3; end
        2: begin x = 0; y = 0; z = 0; end
        3: begin x = $urandom_range(1) ? 16'sh7fff : 16'sh8000; end
        default: ;
      endcase
      send_plain(x, y, z);
    end
  endtask

  // directed rows; typed rows hold their expected pairs at length 256
  row_t dir_rows [] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1}},
    '{16'sd1, 16'sd0, 16'sd0, 1'b1,
      '{16'sd0, -16'sd256, 16'sd0, 16'sd0, 16'sd0, -16'sd256, 1'b0}},
    '{16'sd0, 16'sd1, 16'sd0, 1'b1,
      '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd256, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd5, 1'b1,
      '{16'sd256, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 1'b0}},
    '{16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0, '{default: '0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, '{default: '0}},
    '{16'sh8000, 16'sh7fff, 16'sd0, 1'b0, '{default: '0}},
    '{16'sh7fff, 16'sh8000, 16'sh8000, 1'b0, '{default: '0}},
    '{-16'sd1, -16'sd1, -16'sd1, 1'b0, '{default: '0}},
    '{16'sd3, -16'sd4, 16'sd12, 1'b0, '{default: '0}},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b0, '{default: '0}},
    '{16'sh5555, 16'shaaaa, 16'sh5555, 1'b0, '{default: '0}}
  };

  initial begin
    req_if.valid = 1'b0;
    req_if.in_x = '0;
    req_if.in_y = '0;
    req_if.in_z = '0;
    res_if.ready = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part at reset length
    foreach (dir_rows[i])
      send_vec('{dir_rows[i].x, dir_rows[i].y, dir_rows[i].z}, dir_rows[i].typed,
               dir_rows[i].pair);

    // zero length and degenerate cross products
    set_length(0);
    send_plain(16'sd0, 16'sd0, 16'sd5);
    send_plain(16'sd7, -16'sd2, 16'sd9);
    send_plain(16'sd0, 16'sd0, 16'sd0);

    // longest length, saturation
    set_length(32767);
    send_plain(16'sd1, 16'sd0, 16'sd0);
    send_plain(-16'sd1, 16'sd0, 16'sd0);
    send_plain(16'sd0, 16'sd0, -16'sd3);
    send_plain(16'sh7fff, 16'sh8000, 16'sh7fff);

    // random phases across lengths, one with the receiver held off
    set_length(1);
    random_batch(100);
    set_length(32767);
    hold_req = 1'b1;
    random_batch(150);
    set_length($urandom_range(32767));
    calm = 1'b1;
    random_batch(150);
    calm = 1'b0;
    set_length(256);
    random_batch(100);
    set_length($urandom_range(4095));
    random_batch(100);

    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("** perpendicular_vector_pair: PASSED **");
    else $display("** perpendicular_vector_pair: FAILED **");
    $finish;
  end

  // overall limit
  initial begin
    #2ms;
    $display("** perpendicular_vector_pair: FAILED **");
    $finish;
  end

endmodule
